/* src/assert_macros.svh */
// Assertion macros shared by the RTL of the median finder.
// Checks compile only when SYNTHESIS is not defined; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Condition must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, cond, msg)
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

/* src/smf_pkg.sv */
// Shared widths for the sorting median finder.
// No dependencies.
`default_nettype none

package smf_pkg;

  // Field widths fixed by the interface
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned MED_W   = 33;
  localparam int unsigned COUNT_W = 11;

endpackage

`default_nettype wire

/* src/smf_ram.sv */
// Value store bank: one write port, two registered read ports.
// Depends on smf_pkg for the word width.
`default_nettype none

module smf_ram
  import smf_pkg::*;
#(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [AW-1:0]      waddr_i,
  input  logic [VALUE_W-1:0] wdata_i,
  input  logic [AW-1:0]      raddr0_i,
  input  logic [AW-1:0]      raddr1_i,
  output logic [VALUE_W-1:0] rdata0_o,
  output logic [VALUE_W-1:0] rdata1_o
);

  logic [VALUE_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read ports, data registered
  always_ff @(posedge clk_i) begin
    rdata0_o <= mem[raddr0_i];
    rdata1_o <= mem[raddr1_i];
  end

endmodule

`default_nettype wire

/* src/sorting_median_finder_unit.sv */
// Sorting median finder: loads a set, merge sorts it between two store banks
// and returns twice the median. Depends on smf_pkg, smf_ram, assert_macros.svh.
//
//   channel | handshake               | words
//   --------+-------------------------+-------------------------------------
//   in      | in_valid_i / in_ready_o | sample_value_i, is_last_i
//   out     | out_valid_o/out_ready_i | median_doubled_o, item_count_o,
//           |                         | empty_set_o, overflowed_o
//
// After the last word a bottom-up merge sort runs ceil(log2(n)) passes; each
// run pair is set up in S_RUN, then merged word by word in S_RD and S_MRG.
// The median is read in S_MED_RD and formed in S_MED. in_ready_o is low from
// the last word until the result is in the output register; a stalled output
// holds the finished result and the next set may load. No clearing pass after
// reset.
`default_nettype none
`include "assert_macros.svh"

module sorting_median_finder_unit
  import smf_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [VALUE_W-1:0] sample_value_i,
  input  logic                      is_last_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [MED_W-1:0]   median_doubled_o,
  output logic [COUNT_W-1:0]        item_count_o,
  output logic                      empty_set_o,
  output logic                      overflowed_o
);

  localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned XW = CW + 2;
  localparam int unsigned EW = (CW > COUNT_W) ? CW : COUNT_W;

  typedef enum logic [2:0] {
    S_LOAD,
    S_RUN,
    S_RD,
    S_MRG,
    S_MED_RD,
    S_MED
  } state_e;

  state_e state_q;

  logic [CW-1:0] fill_q;
  logic          ovf_q;
  logic          ovf_res_q;
  logic [CW-1:0] n_q;
  logic          src_q;
  logic [XW-1:0] w_q, k_q, a_q, b_q, mid_q, hi_q;
  logic          out_valid_q;
  logic signed [MED_W-1:0] med_q;
  logic [COUNT_W-1:0]      cnt_q;
  logic                    empty_q;
  logic                    ovf_out_q;

  logic          accept;
  logic          room;
  logic [CW-1:0] n_next;
  logic          out_free;

  // store banks
  logic [AW-1:0]      waddr, raddr0, raddr1;
  logic [VALUE_W-1:0] wdata;
  logic               we0, we1;
  logic [VALUE_W-1:0] d0_b0, d1_b0, d0_b1, d1_b1;
  logic [VALUE_W-1:0] da, db;

  // merge datapath
  logic          take_a;
  logic [XW-1:0] n_x, sum_w, sum_2w, k_nx, w_dbl;
  logic [CW-1:0] half, mlo;
  logic signed [MED_W-1:0] med_sum;
  logic [EW-1:0] n_ext;

  assign in_ready_o = (state_q == S_LOAD);
  assign accept     = in_valid_i && in_ready_o;
  assign room       = (fill_q < CW'(MAX_ITEMS));
  assign n_next     = room ? fill_q + CW'(1) : fill_q;
  assign out_free   = !out_valid_q || out_ready_i;

  // run bounds and comparator
  assign n_x    = XW'(n_q);
  assign sum_w  = k_q + w_q;
  assign sum_2w = k_q + (w_q << 1);
  assign k_nx   = k_q + XW'(1);
  assign w_dbl  = w_q << 1;
  assign da     = src_q ? d0_b1 : d0_b0;
  assign db     = src_q ? d1_b1 : d1_b0;
  assign take_a = (a_q < mid_q) &&
                  ((b_q >= hi_q) || ($signed(da) <= $signed(db)));

  // median addresses: the two middle entries, or the middle one twice
  assign half = n_q >> 1;
  assign mlo  = n_q[0] ? half : half - CW'(1);
  assign med_sum = $signed({da[VALUE_W-1], da}) + $signed({db[VALUE_W-1], db});
  assign n_ext   = EW'(n_q);

  // bank port steering
  always_comb begin
    if (state_q == S_MED_RD || state_q == S_MED) begin
      raddr0 = mlo[AW-1:0];
      raddr1 = half[AW-1:0];
    end else begin
      raddr0 = a_q[AW-1:0];
      raddr1 = b_q[AW-1:0];
    end
    if (state_q == S_LOAD) begin
      waddr = fill_q[AW-1:0];
      wdata = sample_value_i;
    end else begin
      waddr = k_q[AW-1:0];
      wdata = take_a ? da : db;
    end
    we0 = (accept && room) || (state_q == S_MRG && src_q);
    we1 = (state_q == S_MRG) && !src_q;
  end

  smf_ram #(.DEPTH(MAX_ITEMS), .AW(AW)) u_bank0 (
    .clk_i   (clk_i),
    .we_i    (we0),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr0_i(raddr0),
    .raddr1_i(raddr1),
    .rdata0_o(d0_b0),
    .rdata1_o(d1_b0)
  );

  smf_ram #(.DEPTH(MAX_ITEMS), .AW(AW)) u_bank1 (
    .clk_i   (clk_i),
    .we_i    (we1),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr0_i(raddr0),
    .raddr1_i(raddr1),
    .rdata0_o(d0_b1),
    .rdata1_o(d1_b1)
  );

  // sequencer, counters and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      fill_q      <= '0;
      ovf_q       <= 1'b0;
      ovf_res_q   <= 1'b0;
      n_q         <= '0;
      src_q       <= 1'b0;
      w_q         <= '0;
      k_q         <= '0;
      a_q         <= '0;
      b_q         <= '0;
      mid_q       <= '0;
      hi_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // the median step reloads the output register itself
      if (out_valid_q && out_ready_i && (state_q != S_MED)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_LOAD: begin
          if (accept) begin
            if (is_last_i) begin
              n_q       <= n_next;
              ovf_res_q <= ovf_q || !room;
              fill_q    <= '0;
              ovf_q     <= 1'b0;
              src_q     <= 1'b0;
              w_q       <= XW'(1);
              k_q       <= '0;
              state_q   <= (n_next > CW'(1)) ? S_RUN : S_MED_RD;
            end else begin
              fill_q <= n_next;
              ovf_q  <= ovf_q || !room;
            end
          end
        end
        // set up the run pair starting at k
        S_RUN: begin
          a_q     <= k_q;
          mid_q   <= (sum_w < n_x) ? sum_w : n_x;
          b_q     <= (sum_w < n_x) ? sum_w : n_x;
          hi_q    <= (sum_2w < n_x) ? sum_2w : n_x;
          state_q <= S_RD;
        end
        S_RD: begin
          state_q <= S_MRG;
        end
        // one word of the merge goes to the other bank
        S_MRG: begin
          if (take_a) begin
            a_q <= a_q + XW'(1);
          end else begin
            b_q <= b_q + XW'(1);
          end
          if (k_nx == hi_q) begin
            if (hi_q == n_x) begin
              src_q   <= !src_q;
              w_q     <= w_dbl;
              k_q     <= '0;
              state_q <= (w_dbl >= n_x) ? S_MED_RD : S_RUN;
            end else begin
              k_q     <= k_nx;
              state_q <= S_RUN;
            end
          end else begin
            k_q     <= k_nx;
            state_q <= S_RD;
          end
        end
        S_MED_RD: begin
          state_q <= S_MED;
        end
        S_MED: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_LOAD;
          end
        end
        default: begin
          state_q <= S_LOAD;
        end
      endcase
    end
  end

  // result word, loaded as the sequencer leaves the median step
  always_ff @(posedge clk_i) begin
    if (state_q == S_MED && out_free) begin
      med_q     <= (n_q == '0) ? '0 : med_sum;
      cnt_q     <= n_ext[COUNT_W-1:0];
      empty_q   <= (n_q == '0);
      ovf_out_q <= ovf_res_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign median_doubled_o = med_q;
  assign item_count_o     = cnt_q;
  assign empty_set_o      = empty_q;
  assign overflowed_o     = ovf_out_q;

  // checks
  `ASSERT_ALWAYS(a_fill_bound, clk_i, rst_ni, fill_q <= CW'(MAX_ITEMS), "fill count past store depth")
  `ASSERT_IMPL(a_merge_bounds, clk_i, rst_ni, state_q == S_MRG, (a_q <= mid_q) && (b_q <= hi_q) && (k_q < hi_q) && (k_q == a_q + b_q - mid_q), "merge pointers out of step")
  `ASSERT_NEXT(a_last_busy, clk_i, rst_ni, accept && is_last_i, !in_ready_o, "ready after last word")
  `ASSERT_ALWAYS(a_empty_count, clk_i, rst_ni, !(out_valid_o && empty_set_o && (item_count_o != '0)), "empty flag with nonzero count")

endmodule

`default_nettype wire
